// ----- src/vbs_pkg.sv -----
// ----------------------------------------------------------------------------
// vbs_pkg: shared types and constants of the vibration burst statistics unit
// Command and status groups between controller and datapath, register
// indexes and fixed field widths.
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COUNT_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int RESULT_W   = 24;
    localparam int ENERGY_W   = 48;
    localparam int SUMSQ_W    = 47;
    localparam int CHUNK_W    = 49;
    localparam int CFG_IDX_W  = 8;
    localparam int AXIS_W     = 2;
    localparam int STEP_W     = 6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 8'd1;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 16'd1024;
    localparam logic [SCALE_W-1:0] SCALE_RESET        = 24'd65536;

    // floor(x/3) == (x * RECIP3) >> 17 for any 16-bit x
    localparam logic [15:0] RECIP3 = 16'd43691;

    // operation issued to the shared multiplier, consumed in the cycle after it is issued
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_RMS,
        MUL_PEAK,
        MUL_SS,
        MUL_E00,
        MUL_E01,
        MUL_E10,
        MUL_E11
    } mul_op_t;

    typedef struct packed {
        logic                accept;
        logic                clear;
        logic                div_load;
        logic                div_step;
        logic                sqrt_load;
        logic                sqrt_step;
        mul_op_t             mul_op;
        logic [AXIS_W-1:0]   axis;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

// ----- src/vbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// vbs_ctrl: burst sequencer
// Runs the accumulate phase, then steps the divider, square root and
// multiplier through the end-of-burst arithmetic, and owns the handshakes.
// ----------------------------------------------------------------------------
module vbs_ctrl
    import vbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_ACC,
        S_DRAIN,
        S_DIV,
        S_SQRT,
        S_RMS,
        S_PEAK,
        S_SS,
        S_SSWAIT,
        S_ENERGY,
        S_FINISH
    } state_t;

    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'd32;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [AXIS_W-1:0]   axis_reg;
    logic                out_valid_reg;
    logic                accept;

    assign in_ready  = (state_reg == S_ACC);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid & in_ready;

    // commands decoded from state
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.axis      = axis_reg;
        cmd.mul_op    = MUL_NONE;
        unique case (state_reg)
            S_DIV:
            begin
                cmd.div_load = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
            end
            S_SQRT:
            begin
                cmd.sqrt_load = (step_reg == '0);
                cmd.sqrt_step = (step_reg != '0);
            end
            S_RMS:    cmd.mul_op = MUL_RMS;
            S_PEAK:   cmd.mul_op = MUL_PEAK;
            S_SS:     cmd.mul_op = MUL_SS;
            S_ENERGY:
            begin
                unique case (step_reg[1:0])
                    2'd0:    cmd.mul_op = MUL_E00;
                    2'd1:    cmd.mul_op = MUL_E01;
                    2'd2:    cmd.mul_op = MUL_E10;
                    default: cmd.mul_op = MUL_E11;
                endcase
            end
            S_FINISH: cmd.clear = 1'b1;
            default:  cmd.clear = 1'b0;
        endcase
    end

    // state, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            step_reg      <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_ACC:
                begin
                    if (accept && status.last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // results are written straight into the output registers
                    if (!out_valid_reg)
                    begin
                        state_reg <= S_DIV;
                        step_reg  <= '0;
                        axis_reg  <= '0;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == DIV_LAST)
                    begin
                        state_reg <= S_SQRT;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_SQRT:
                begin
                    if (step_reg == SQRT_LAST)
                    begin
                        state_reg <= S_RMS;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_RMS:
                begin
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_reg <= S_PEAK;
                        axis_reg  <= '0;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                        axis_reg  <= axis_reg + 1'b1;
                    end
                end
                S_PEAK:
                begin
                    if (axis_reg == AXIS_LAST)
                    begin
                        state_reg <= S_SS;
                        axis_reg  <= '0;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                S_SS:     state_reg <= S_SSWAIT;
                S_SSWAIT:
                begin
                    state_reg <= S_ENERGY;
                    step_reg  <= '0;
                    axis_reg  <= '0;
                end
                S_ENERGY:
                begin
                    if (step_reg[1:0] == 2'd3)
                    begin
                        step_reg <= '0;
                        if (axis_reg == AXIS_LAST)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_ACC;
                end
                default:  state_reg <= S_ACC;
            endcase
        end
    end

endmodule

// ----- src/vbs_datapath.sv -----
// ----------------------------------------------------------------------------
// vbs_datapath: accumulators and end-of-burst arithmetic
// Two-stage sample pipeline (abs and square, then accumulate), a radix-2
// divider, a digit-serial square root and one shared 32x24 multiplier.
// ----------------------------------------------------------------------------
module vbs_datapath
    import vbs_pkg::*;
#(
    parameter int MAX_SAMPLES = 65535
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SCALE_W-1:0]      cfg_data,
    input  logic [SAMPLE_W-1:0]     sample_x,
    input  logic [SAMPLE_W-1:0]     sample_y,
    input  logic [SAMPLE_W-1:0]     sample_z,
    input  cmd_t                    cmd,
    output status_t                 status,
    output logic [RESULT_W-1:0]     rms_x,
    output logic [RESULT_W-1:0]     rms_y,
    output logic [RESULT_W-1:0]     rms_z,
    output logic [RESULT_W-1:0]     peak_x,
    output logic [RESULT_W-1:0]     peak_y,
    output logic [RESULT_W-1:0]     peak_z,
    output logic [ENERGY_W-1:0]     energy_first,
    output logic [ENERGY_W-1:0]     energy_second,
    output logic [ENERGY_W-1:0]     energy_third
);

    localparam logic [COUNT_W-1:0] COUNT_CLAMP =
        (MAX_SAMPLES > 65535) ? 16'hFFFF : COUNT_W'(MAX_SAMPLES);
    localparam int ACC_W = 97;

    // configuration
    logic [COUNT_W-1:0]   sample_count_reg;
    logic [SCALE_W-1:0]   scale_reg;

    // burst state
    logic [COUNT_W-1:0]   sample_index_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [SUMSQ_W-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic [15:0]          pk_x_reg, pk_y_reg, pk_z_reg;
    logic [CHUNK_W-1:0]   chunk0_reg, chunk1_reg, chunk2_reg;

    // first pipeline stage
    logic                 s1_valid_reg;
    logic [1:0]           s1_band_reg;
    logic [15:0]          s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic [31:0]          s1_qx_reg, s1_qy_reg, s1_qz_reg;

    // divider and square root
    logic [63:0]          wk_reg;
    logic [15:0]          div_rem_reg;
    logic [33:0]          sq_rem_reg;
    logic [31:0]          root_reg;

    // multiplier
    mul_op_t              mul_op_reg;
    logic [AXIS_W-1:0]    mul_axis_reg;
    logic [55:0]          mul_p_reg;
    logic [47:0]          ss_reg;
    logic [ACC_W-1:0]     acc_reg;

    // output registers
    logic [RESULT_W-1:0]  rms_x_reg, rms_y_reg, rms_z_reg;
    logic [RESULT_W-1:0]  peak_x_reg, peak_y_reg, peak_z_reg;
    logic [ENERGY_W-1:0]  en0_reg, en1_reg, en2_reg;

    logic [COUNT_W-1:0]   count_eff;
    logic [31:0]          c_prod;
    logic [COUNT_W-1:0]   chunk_len;
    logic [COUNT_W-1:0]   chunk_len2;
    logic [1:0]           band;
    logic [15:0]          ax, ay, az;
    logic [33:0]          mag_sq;

    logic [SUMSQ_W-1:0]   sumsq_sel;
    logic [15:0]          pk_sel;
    logic [CHUNK_W-1:0]   chunk_sel;
    logic [16:0]          div_t;
    logic                 div_ge;
    logic [16:0]          div_diff;
    logic [35:0]          sq_t;
    logic [35:0]          sq_trial;
    logic                 sq_ge;
    logic [35:0]          sq_diff;
    logic [31:0]          mul_a;
    logic [23:0]          mul_b;
    logic [RESULT_W-1:0]  rms_val;
    logic [RESULT_W-1:0]  peak_val;
    logic [ACC_W-1:0]     energy_tot;
    logic [ENERGY_W-1:0]  energy_val;

    // effective burst length and chunk boundaries
    always_comb
    begin
        count_eff = (sample_count_reg == '0) ? 16'd1 : sample_count_reg;
        if (count_eff > COUNT_CLAMP)
        begin
            count_eff = COUNT_CLAMP;
        end
    end

    assign c_prod     = {16'b0, count_eff} * {16'b0, RECIP3};
    assign chunk_len  = {1'b0, c_prod[31:17]};
    assign chunk_len2 = {chunk_len[14:0], 1'b0};

    always_comb
    begin
        priority if (sample_index_reg < chunk_len)
        begin
            band = 2'd0;
        end
        else if (sample_index_reg < chunk_len2)
        begin
            band = 2'd1;
        end
        else
        begin
            band = 2'd2;
        end
    end

    assign status.last = ({1'b0, sample_index_reg} + 17'd1) >= {1'b0, count_eff};

    // absolute values of the raw samples
    assign ax = sample_x[15] ? (~sample_x + 16'd1) : sample_x;
    assign ay = sample_y[15] ? (~sample_y + 16'd1) : sample_y;
    assign az = sample_z[15] ? (~sample_z + 16'd1) : sample_z;

    assign mag_sq = {2'b0, s1_qx_reg} + {2'b0, s1_qy_reg} + {2'b0, s1_qz_reg};

    // operand selection by axis or chunk
    always_comb
    begin
        unique case (cmd.axis)
            2'd0:
            begin
                sumsq_sel = sum_x_reg;
                pk_sel    = pk_x_reg;
                chunk_sel = chunk0_reg;
            end
            2'd1:
            begin
                sumsq_sel = sum_y_reg;
                pk_sel    = pk_y_reg;
                chunk_sel = chunk1_reg;
            end
            default:
            begin
                sumsq_sel = sum_z_reg;
                pk_sel    = pk_z_reg;
                chunk_sel = chunk2_reg;
            end
        endcase
    end

    // restoring divider step, one quotient bit a cycle
    assign div_t    = {div_rem_reg, wk_reg[62]};
    assign div_ge   = div_t >= {1'b0, n_reg};
    assign div_diff = div_t - {1'b0, n_reg};

    // square root step, one root bit a cycle
    assign sq_t     = {sq_rem_reg, wk_reg[63:62]};
    assign sq_trial = {2'b0, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign sq_diff  = sq_t - sq_trial;

    // multiplier operands
    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_RMS:
            begin
                mul_a = root_reg;
                mul_b = scale_reg;
            end
            MUL_PEAK:
            begin
                mul_a = {16'b0, pk_sel};
                mul_b = scale_reg;
            end
            MUL_SS:
            begin
                mul_a = {8'b0, scale_reg};
                mul_b = scale_reg;
            end
            MUL_E00:
            begin
                mul_a = {8'b0, chunk_sel[23:0]};
                mul_b = ss_reg[23:0];
            end
            MUL_E01:
            begin
                mul_a = {8'b0, chunk_sel[23:0]};
                mul_b = ss_reg[47:24];
            end
            MUL_E10:
            begin
                mul_a = {7'b0, chunk_sel[48:24]};
                mul_b = ss_reg[23:0];
            end
            MUL_E11:
            begin
                mul_a = {7'b0, chunk_sel[48:24]};
                mul_b = ss_reg[47:24];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // saturating result formats
    assign rms_val    = (mul_p_reg[55:40] != '0) ? '1 : mul_p_reg[39:16];
    assign peak_val   = (mul_p_reg[55:32] != '0) ? '1 : mul_p_reg[31:8];
    assign energy_tot = acc_reg + {mul_p_reg[48:0], 48'b0};
    assign energy_val = (energy_tot[96:80] != '0) ? '1 : energy_tot[79:32];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RESET;
            scale_reg        <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SAMPLE_COUNT)
            begin
                sample_count_reg <= cfg_data[15:0];
            end
            else if (cfg_index == REG_SCALE)
            begin
                scale_reg <= cfg_data;
            end
        end
    end

    // sample pipeline and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            sample_index_reg <= '0;
            n_reg            <= 16'd1;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_z_reg        <= '0;
            pk_x_reg         <= '0;
            pk_y_reg         <= '0;
            pk_z_reg         <= '0;
            chunk0_reg       <= '0;
            chunk1_reg       <= '0;
            chunk2_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= cmd.accept;
            if (cmd.accept)
            begin
                if (status.last)
                begin
                    n_reg            <= sample_index_reg + 16'd1;
                    sample_index_reg <= '0;
                end
                else
                begin
                    sample_index_reg <= sample_index_reg + 16'd1;
                end
            end
            if (cmd.clear)
            begin
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_z_reg  <= '0;
                pk_x_reg   <= '0;
                pk_y_reg   <= '0;
                pk_z_reg   <= '0;
                chunk0_reg <= '0;
                chunk1_reg <= '0;
                chunk2_reg <= '0;
            end
            else if (s1_valid_reg)
            begin
                sum_x_reg <= sum_x_reg + {15'b0, s1_qx_reg};
                sum_y_reg <= sum_y_reg + {15'b0, s1_qy_reg};
                sum_z_reg <= sum_z_reg + {15'b0, s1_qz_reg};
                if (s1_ax_reg > pk_x_reg) pk_x_reg <= s1_ax_reg;
                if (s1_ay_reg > pk_y_reg) pk_y_reg <= s1_ay_reg;
                if (s1_az_reg > pk_z_reg) pk_z_reg <= s1_az_reg;
                unique case (s1_band_reg)
                    2'd0:    chunk0_reg <= chunk0_reg + {15'b0, mag_sq};
                    2'd1:    chunk1_reg <= chunk1_reg + {15'b0, mag_sq};
                    default: chunk2_reg <= chunk2_reg + {15'b0, mag_sq};
                endcase
            end
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_band_reg <= band;
            s1_ax_reg   <= ax;
            s1_ay_reg   <= ay;
            s1_az_reg   <= az;
            s1_qx_reg   <= {16'b0, ax} * {16'b0, ax};
            s1_qy_reg   <= {16'b0, ay} * {16'b0, ay};
            s1_qz_reg   <= {16'b0, az} * {16'b0, az};
        end
    end

    // divider and square root working registers
    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            wk_reg      <= {1'b0, sumsq_sel, 16'b0};
            div_rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            wk_reg      <= {1'b0, wk_reg[61:0], div_ge};
            div_rem_reg <= div_ge ? div_diff[15:0] : div_t[15:0];
        end
        else if (cmd.sqrt_load)
        begin
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            wk_reg     <= {wk_reg[61:0], 2'b00};
            sq_rem_reg <= sq_ge ? sq_diff[33:0] : sq_t[33:0];
            root_reg   <= {root_reg[30:0], sq_ge};
        end
    end

    // multiplier issue tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_op_reg <= MUL_NONE;
        end
        else
        begin
            mul_op_reg <= cmd.mul_op;
        end
    end

    // multiplier product and consumers
    always_ff @(posedge clk)
    begin
        mul_p_reg    <= {24'b0, mul_a} * {32'b0, mul_b};
        mul_axis_reg <= cmd.axis;
        unique case (mul_op_reg)
            MUL_RMS:
            begin
                unique case (mul_axis_reg)
                    2'd0:    rms_x_reg <= rms_val;
                    2'd1:    rms_y_reg <= rms_val;
                    default: rms_z_reg <= rms_val;
                endcase
            end
            MUL_PEAK:
            begin
                unique case (mul_axis_reg)
                    2'd0:    peak_x_reg <= peak_val;
                    2'd1:    peak_y_reg <= peak_val;
                    default: peak_z_reg <= peak_val;
                endcase
            end
            MUL_SS:  ss_reg  <= mul_p_reg[47:0];
            MUL_E00: acc_reg <= {41'b0, mul_p_reg};
            MUL_E01: acc_reg <= acc_reg + {17'b0, mul_p_reg[55:0], 24'b0};
            MUL_E10: acc_reg <= acc_reg + {17'b0, mul_p_reg[55:0], 24'b0};
            MUL_E11:
            begin
                unique case (mul_axis_reg)
                    2'd0:    en0_reg <= energy_val;
                    2'd1:    en1_reg <= energy_val;
                    default: en2_reg <= energy_val;
                endcase
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    assign rms_x         = rms_x_reg;
    assign rms_y         = rms_y_reg;
    assign rms_z         = rms_z_reg;
    assign peak_x        = peak_x_reg;
    assign peak_y        = peak_y_reg;
    assign peak_z        = peak_z_reg;
    assign energy_first  = en0_reg;
    assign energy_second = en1_reg;
    assign energy_third  = en2_reg;

endmodule

// ----- src/vibration_burst_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// vibration_burst_statistics_unit: RMS, peak and chunk energy of a burst
// Accumulates three-axis samples and reports per-axis RMS and peak and the
// squared magnitude of three time chunks once per burst.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in_valid/in_ready    sample_x, sample_y, sample_z
//  out      out_valid/out_ready  rms_x/y/z, peak_x/y/z, energy_first/second/third
//
//  during a burst one sample request is taken every cycle
//  after the last sample the end-of-burst arithmetic runs the bit-serial divider
//  and square root once per axis
//  results sit in the output registers; the next burst is accepted meanwhile,
//  and its arithmetic starts only once the previous result has been taken
//  reset clears the sample accumulators and loads the register defaults
//
module vibration_burst_statistics_unit
    import vbs_pkg::*;
#(
    parameter int MAX_SAMPLES = 65535
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SCALE_W-1:0]      cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_W-1:0]     sample_x,
    input  logic [SAMPLE_W-1:0]     sample_y,
    input  logic [SAMPLE_W-1:0]     sample_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [RESULT_W-1:0]     rms_x,
    output logic [RESULT_W-1:0]     rms_y,
    output logic [RESULT_W-1:0]     rms_z,
    output logic [RESULT_W-1:0]     peak_x,
    output logic [RESULT_W-1:0]     peak_y,
    output logic [RESULT_W-1:0]     peak_z,
    output logic [ENERGY_W-1:0]     energy_first,
    output logic [ENERGY_W-1:0]     energy_second,
    output logic [ENERGY_W-1:0]     energy_third
);

    cmd_t    cmd;
    status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    vbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    vbs_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .sample_z      (sample_z),
        .cmd           (cmd),
        .status        (status),
        .rms_x         (rms_x),
        .rms_y         (rms_y),
        .rms_z         (rms_z),
        .peak_x        (peak_x),
        .peak_y        (peak_y),
        .peak_z        (peak_z),
        .energy_first  (energy_first),
        .energy_second (energy_second),
        .energy_third  (energy_third)
    );

endmodule
